>>> src/bba_pkg.sv
// shared constants and codes for the block bitmap allocator
package bba_pkg;

    // field widths of the channels
    localparam int CMD_W    = 2;
    localparam int BLK_W    = 12;
    localparam int STATUS_W = 2;
    localparam int TOTAL_W  = 13;

    // default sizing
    localparam int DEF_MAX_BLOCKS    = 4096;
    localparam int DEF_MAP_WORD_BITS = 32;

    // command codes
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FREE_ZERO = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd3;

endpackage

>>> src/bba_cmd_if.sv
// command channel: one command with its block number
interface bba_cmd_if;
    import bba_pkg::*;

    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] cmd;
    logic [BLK_W-1:0] block_number;

    modport source (output valid, output cmd, output block_number, input ready);
    modport sink   (input valid, input cmd, input block_number, output ready);
endinterface

>>> src/bba_rsp_if.sv
// result channel: one answer per command
interface bba_rsp_if;
    import bba_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [BLK_W-1:0]    allocated_block;
    logic                is_free;

    modport source (output valid, output status, output allocated_block, output is_free,
                    input ready);
    modport sink   (input valid, input status, input allocated_block, input is_free,
                    output ready);
endinterface

>>> src/bba_cfg_if.sv
// configuration write channel for the block total
interface bba_cfg_if;
    import bba_pkg::*;

    logic               valid;
    logic               ready;
    logic [TOTAL_W-1:0] total_blocks;

    modport source (output valid, output total_blocks, input ready);
    modport sink   (input valid, input total_blocks, output ready);
endinterface

>>> src/bba_map_ram.sv
// single write port, single registered read port bitmap store
module bba_map_ram #(
    parameter int DEPTH = 128,
    parameter int AW    = 7,
    parameter int DW    = 32
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> src/bba_word_scan.sv
// first-free search over one bitmap word, limited to blocks below the total
module bba_word_scan #(
    parameter int PW = 32,
    parameter int SH = 5,
    parameter int TW = 13,
    parameter int BW = 14
) (
    input  logic [PW-1:0] word,
    input  logic [BW-1:0] base,
    input  logic [TW-1:0] total,
    output logic          exhausted,
    output logic          found,
    output logic [SH-1:0] pos
);

    logic [BW-1:0] rem;
    logic [PW-1:0] hit;

    // blocks left before the total, counted from this word's first block
    assign rem       = BW'(total) - base;
    assign exhausted = (base >= BW'(total));

    always_comb
    begin
        for (int j = 0; j < PW; j++)
        begin
            hit[j] = word[j] && (BW'(j) < rem);
        end
    end

    // lowest set bit wins
    always_comb
    begin
        found = 1'b0;
        pos   = '0;
        for (int j = PW - 1; j >= 0; j--)
        begin
            if (hit[j])
            begin
                found = 1'b1;
                pos   = SH'(j);
            end
        end
    end

endmodule

>>> src/block_bitmap_allocator_unit.sv
// top level of the first-fit block bitmap allocator
// first-fit free-block allocator over a bitmap with one bit per block, 1 meaning
// free. after reset the block runs a clearing pass over the bitmap store, one
// word per cycle over MAX_BLOCKS / word size rounded up words (128 by default),
// with req.ready low; configuration writes are taken at any time. query and free
// go through one registered read of the bitmap store at the accepting edge, a
// check (and read-modify-write for free), and the load into the output register.
// allocate reads one bitmap word per cycle from word zero and stops at the first
// word holding a free block below the total, at the first word that starts at or
// past the total, or at the last word; the single read port of the bitmap store
// and the one-word search unit set that rate. the block works on one command at
// a time and is ready again once the result is loaded into the output register.
// the output load waits while the output register holds a result that does not
// transfer. a finished result sits in the output register and the next command
// is accepted while it waits to transfer. bitmap words are held MAP_WORD_BITS
// wide rounded up to a power of two.
module block_bitmap_allocator_unit #(
    parameter int MAX_BLOCKS    = bba_pkg::DEF_MAX_BLOCKS,
    parameter int MAP_WORD_BITS = bba_pkg::DEF_MAP_WORD_BITS
) (
    input  logic      clk,
    input  logic      rst_n,
    bba_cmd_if.sink   req,
    bba_rsp_if.source rsp,
    bba_cfg_if.sink   cfg
);
    import bba_pkg::*;

    // word geometry, word width rounded up to a power of two
    localparam int SH    = $clog2(MAP_WORD_BITS);
    localparam int PW    = 1 << SH;
    localparam int DEPTH = (MAX_BLOCKS + PW - 1) / PW;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    // total width: holds both the register and MAX_BLOCKS
    localparam int CW    = $clog2(MAX_BLOCKS + 1);
    localparam int TW    = (CW > TOTAL_W) ? CW : TOTAL_W;
    localparam int BW    = TW + 1;

    // sequencer states
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [AW-1:0]       clr_reg, clr_next;
    logic [TOTAL_W-1:0]  total_reg;
    logic [CMD_W-1:0]    cmd_reg;
    logic [BLK_W-1:0]    blk_reg;
    logic [AW-1:0]       idx_reg, idx_next;

    // pending result, waiting for the output register
    logic [STATUS_W-1:0] pend_status_reg, pend_status_next;
    logic [BLK_W-1:0]    pend_alloc_reg, pend_alloc_next;
    logic                pend_free_reg, pend_free_next;

    // output register
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg;
    logic [BLK_W-1:0]    out_alloc_reg;
    logic                out_free_reg;

    // bitmap store ports
    logic          we, re;
    logic [AW-1:0] waddr, raddr;
    logic [PW-1:0] wdata, rdata;

    // scan unit
    logic [BW-1:0] base;
    logic          exhausted, found;
    logic [SH-1:0] pos;

    logic [TW-1:0] eff_total;
    logic          req_xfer, out_load;
    logic [AW-1:0] blk_word, in_word;
    logic [SH-1:0] blk_bit;
    logic          blk_in_range;
    logic          last_word;

    // a total above the store size acts as the store size
    assign eff_total = (TW'(total_reg) > TW'(MAX_BLOCKS)) ? TW'(MAX_BLOCKS) : TW'(total_reg);

    assign req.ready = (state_reg == S_IDLE);
    assign req_xfer  = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    assign in_word      = AW'(req.block_number >> SH);
    assign blk_word     = AW'(blk_reg >> SH);
    assign blk_bit      = blk_reg[SH-1:0];
    assign blk_in_range = (TW'(blk_reg) < eff_total);
    assign last_word    = (idx_reg == AW'(DEPTH - 1));
    assign base         = BW'({idx_reg, {SH{1'b0}}});

    // output register frees up when empty or when its result transfers
    assign out_load = (state_reg == S_FIN) && (!out_valid_reg || rsp.ready);

    assign rsp.valid           = out_valid_reg;
    assign rsp.status          = out_status_reg;
    assign rsp.allocated_block = out_alloc_reg;
    assign rsp.is_free         = out_free_reg;

    bba_map_ram #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (PW)
    ) u_map (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    bba_word_scan #(
        .PW (PW),
        .SH (SH),
        .TW (TW),
        .BW (BW)
    ) u_scan (
        .word      (rdata),
        .base      (base),
        .total     (eff_total),
        .exhausted (exhausted),
        .found     (found),
        .pos       (pos)
    );

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        clr_next         = clr_reg;
        idx_next         = idx_reg;
        pend_status_next = pend_status_reg;
        pend_alloc_next  = pend_alloc_reg;
        pend_free_next   = pend_free_reg;
        we               = 1'b0;
        waddr            = '0;
        wdata            = '0;
        re               = 1'b0;
        raddr            = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                // zero one word per cycle, every block starts in use
                we    = 1'b1;
                waddr = clr_reg;
                wdata = '0;
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
                clr_next = clr_reg + 1'b1;
            end

            S_IDLE:
            begin
                if (req_xfer)
                begin
                    pend_status_next = ST_OK;
                    pend_alloc_next  = '0;
                    pend_free_next   = 1'b0;
                    idx_next         = '0;
                    if (req.cmd == CMD_ALLOC)
                    begin
                        // scan starts at word zero
                        re         = 1'b1;
                        raddr      = '0;
                        state_next = S_SCAN;
                    end
                    else if (req.cmd == CMD_QUERY || req.cmd == CMD_FREE)
                    begin
                        re         = 1'b1;
                        raddr      = in_word;
                        state_next = S_CHECK;
                    end
                    else
                    begin
                        // unused command answers all zero
                        state_next = S_FIN;
                    end
                end
            end

            S_CHECK:
            begin
                state_next = S_FIN;
                if (cmd_reg == CMD_QUERY)
                begin
                    pend_free_next = blk_in_range && rdata[blk_bit];
                end
                else
                begin
                    priority if (blk_reg == '0)
                    begin
                        pend_status_next = ST_FREE_ZERO;
                    end
                    else if (!blk_in_range)
                    begin
                        pend_status_next = ST_RANGE;
                    end
                    else
                    begin
                        // read-modify-write sets the free bit
                        we    = 1'b1;
                        waddr = blk_word;
                        wdata = rdata | (PW'(1) << blk_bit);
                    end
                end
            end

            S_SCAN:
            begin
                priority if (exhausted)
                begin
                    pend_status_next = ST_NO_SPACE;
                    state_next       = S_FIN;
                end
                else if (found)
                begin
                    // claim the block: clear its bit
                    we               = 1'b1;
                    waddr            = idx_reg;
                    wdata            = rdata & ~(PW'(1) << pos);
                    pend_status_next = ST_OK;
                    pend_alloc_next  = BLK_W'(base + BW'(pos));
                    state_next       = S_FIN;
                end
                else if (last_word)
                begin
                    pend_status_next = ST_NO_SPACE;
                    state_next       = S_FIN;
                end
                else
                begin
                    // next word's read overlaps this word's check
                    re       = 1'b1;
                    raddr    = idx_reg + 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
            end

            S_FIN:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                total_reg <= cfg.total_blocks;
            end
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        idx_reg         <= idx_next;
        pend_status_reg <= pend_status_next;
        pend_alloc_reg  <= pend_alloc_next;
        pend_free_reg   <= pend_free_next;
        if (req_xfer)
        begin
            cmd_reg <= req.cmd;
            blk_reg <= req.block_number;
        end
        if (out_load)
        begin
            out_status_reg <= pend_status_reg;
            out_alloc_reg  <= pend_alloc_reg;
            out_free_reg   <= pend_free_reg;
        end
    end

endmodule

>>> verif/bba_alloc_checker.sv
// checker for the block bitmap allocator: predicts each answer and compares transfers
module bba_alloc_checker (
    input  logic clk,
    input  logic rst_n,
    bba_cmd_if   req,
    bba_rsp_if   rsp,
    bba_cfg_if   cfg,
    output int   mismatches,
    output int   outstanding
);
    import bba_pkg::*;

    localparam int MAP_BLOCKS = DEF_MAX_BLOCKS;
    localparam int PRINT_CAP  = 40;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [BLK_W-1:0]    block;
        logic                free_flag;
    } bba_answer_t;

    bit                 free_bits [MAP_BLOCKS];
    logic [TOTAL_W-1:0] total_cfg;
    bba_answer_t        answers_due [$];

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_CAP)
            $display("mismatch: %s", msg);
        mismatches++;
    endtask

    // runs one command against the local bitmap copy and returns its answer
    function automatic bba_answer_t allocator_answer(input logic [CMD_W-1:0] op,
                                                     input logic [BLK_W-1:0] blk);
        bba_answer_t a;
        int          limit;
        a.status    = ST_OK;
        a.block     = '0;
        a.free_flag = 1'b0;
        // totals above the map size clamp to it
        limit = (total_cfg > MAP_BLOCKS) ? MAP_BLOCKS : int'(total_cfg);
        case (op)
            CMD_QUERY: a.free_flag = (int'(blk) < limit) && free_bits[blk];
            CMD_FREE:
            begin
                if (blk == '0)
                    a.status = ST_FREE_ZERO;
                else if (int'(blk) >= limit)
                    a.status = ST_RANGE;
                else
                    free_bits[blk] = 1'b1;
            end
            CMD_ALLOC:
            begin
                a.status = ST_NO_SPACE;
                for (int b = 0; b < limit; b++)
                begin
                    if (free_bits[b])
                    begin
                        free_bits[b] = 1'b0;
                        a.status     = ST_OK;
                        a.block      = BLK_W'(b);
                        break;
                    end
                end
            end
            default: ;
        endcase
        return a;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        bba_answer_t want;
        if (!rst_n)
        begin
            foreach (free_bits[i])
                free_bits[i] = 1'b0;
            total_cfg = '0;
            answers_due.delete();
            mismatches = 0;
            outstanding <= 0;
        end
        else
        begin
            // results first: a command taken at this edge cannot answer at it
            if (rsp.valid && rsp.ready)
            begin
                if (answers_due.size() == 0)
                    report_mismatch("result transfer with no command waiting");
                else
                begin
                    want = answers_due.pop_front();
                    if (rsp.status !== want.status)
                        report_mismatch($sformatf("status got %0d expected %0d",
                                                  rsp.status, want.status));
                    if (rsp.allocated_block !== want.block)
                        report_mismatch($sformatf("allocated_block got %0d expected %0d",
                                                  rsp.allocated_block, want.block));
                    if (rsp.is_free !== want.free_flag)
                        report_mismatch($sformatf("is_free got %0d expected %0d",
                                                  rsp.is_free, want.free_flag));
                end
            end
            if (cfg.valid && cfg.ready)
                total_cfg = cfg.total_blocks;
            if (req.valid && req.ready)
                answers_due.push_back(allocator_answer(req.cmd, req.block_number));
            outstanding <= answers_due.size();
        end
    end
endmodule

>>> verif/tb_top.sv
// top of the block bitmap allocator testbench: clock, reset, stimulus and verdict
module tb_top;
    import bba_pkg::*;

    // command code the block treats as a no-op
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // bound for the worst allocate scan, which reads every bitmap word
    localparam int SCAN_CYCLES    = 3 + (DEF_MAX_BLOCKS + DEF_MAP_WORD_BITS - 1) / DEF_MAP_WORD_BITS;
    localparam int TAIL_CYCLES    = SCAN_CYCLES + 20;
    // receiver hold-off for the back-pressure test
    localparam int HOLD_CYCLES    = 300;
    // longest quiet stretch in a good run is the hold-off or the reset clearing pass
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASES         = 12;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    bba_cmd_if req ();
    bba_rsp_if rsp ();
    bba_cfg_if cfg ();

    block_bitmap_allocator_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    int mismatch_total;
    int results_due;

    bba_alloc_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .cfg         (cfg),
        .mismatches  (mismatch_total),
        .outstanding (results_due)
    );

    // when set, neither side idles
    bit steady = 1'b0;
    int quiet_cycles = 0;

    // watchdog: ends the run when no transfer of any kind happens for too long
    always @(posedge clk)
    begin
        if (!rst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready)
            || (cfg.valid && cfg.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_top failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // result receiver: random stalls, plus two long hold-offs so the block
    // fills its output register and then stalls the command side
    initial
    begin
        int results_seen;
        int hold_left;
        results_seen = 0;
        hold_left    = 0;
        rsp.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp.valid && rsp.ready)
            begin
                results_seen++;
                if (results_seen == 300 || results_seen == 1100)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp.ready <= 1'b0;
            end
            else
                rsp.ready <= steady || ($urandom_range(99) >= 20);
        end
    end

    // one command transfer, with an occasional gap before it
    // valid stays high afterwards so back-to-back commands need no re-raise
    task automatic issue(input logic [CMD_W-1:0] op, input logic [BLK_W-1:0] blk);
        if (!steady && $urandom_range(99) < 20)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        req.valid        <= 1'b1;
        req.cmd          <= op;
        req.block_number <= blk;
        do @(posedge clk); while (req.ready !== 1'b1);
    endtask

    // write the total only once every answer is back
    task automatic set_total(input logic [TOTAL_W-1:0] value);
        req.valid <= 1'b0;
        // the outstanding count is registered in the checker, so it trails the last command transfer
        do @(posedge clk); while (results_due != 0);
        cfg.valid        <= 1'b1;
        cfg.total_blocks <= value;
        do @(posedge clk); while (cfg.ready !== 1'b1);
        cfg.valid <= 1'b0;
    endtask

    // block number choice: mostly in range and biased low so frees feed allocations
    function automatic logic [BLK_W-1:0] pick_block(input int span);
        int roll;
        roll = $urandom_range(99);
        if (span <= 1 || roll < 10)
            return BLK_W'($urandom);
        else if (roll < 15)
            return '0;
        else if (roll < 20)
            return BLK_W'(span - 1);
        else if (roll < 40)
            return BLK_W'($urandom_range((span - 1 < 40) ? span - 1 : 40));
        else
            return BLK_W'($urandom_range(span - 1));
    endfunction

    // one setting of the total followed by a random command mix
    task automatic run_phase(input logic [TOTAL_W-1:0] total_val, input int n_items);
        int span;
        int done;
        int roll;
        set_total(total_val);
        span = (total_val > DEF_MAX_BLOCKS) ? DEF_MAX_BLOCKS : int'(total_val);
        done = 0;
        while (done < n_items)
        begin
            roll = $urandom_range(99);
            if (roll < 10)
            begin
                // run of allocations, often enough to use up every free block
                repeat ($urandom_range(1, 12))
                begin
                    issue(CMD_ALLOC, BLK_W'($urandom));
                    done++;
                end
            end
            else
            begin
                if (roll < 50)
                    issue(CMD_FREE, pick_block(span));
                else if (roll < 75)
                    issue(CMD_ALLOC, BLK_W'($urandom));
                else if (roll < 95)
                    issue(CMD_QUERY, pick_block(span));
                else
                    issue(CMD_UNUSED, BLK_W'($urandom));
                done++;
            end
        end
    endtask

    initial
    begin
        logic [TOTAL_W-1:0] totals [PHASES];
        int                 counts [PHASES];

        req.valid        = 1'b0;
        req.cmd          = CMD_QUERY;
        req.block_number = '0;
        cfg.valid        = 1'b0;
        cfg.total_blocks = '0;

        // totals cover zero, one, word boundaries, the map size, all ones and
        // just past the map size (clamped)
        totals = '{13'd8191, 13'd0, 13'd1, 13'd32, 13'd33, 13'd4096, 13'd4097,
                   13'd4095, 13'd64, TOTAL_W'($urandom_range(8191)),
                   TOTAL_W'($urandom_range(2, 200)), 13'd4096};
        counts = '{140, 30, 30, 140, 140, 160, 140, 140, 140, 140, 140, 140};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // reset total of zero: nothing is in range
        issue(CMD_ALLOC, '0);           // no free block
        issue(CMD_QUERY, '0);           // out of range reads not free
        issue(CMD_FREE, 12'd5);         // out of range
        issue(CMD_UNUSED, 12'd4095);    // no-op command

        // oversized total acts as the full map
        set_total(13'd8191);
        issue(CMD_FREE, '0);            // block zero is refused
        issue(CMD_FREE, 12'd4095);
        issue(CMD_FREE, 12'd4095);      // already free stays free
        issue(CMD_QUERY, 12'd4095);
        issue(CMD_QUERY, 12'd4094);
        issue(CMD_ALLOC, 12'd4095);     // hands out the last block
        issue(CMD_ALLOC, '0);           // map empty again
        issue(CMD_FREE, 12'd1);
        issue(CMD_FREE, 12'd2);
        issue(CMD_ALLOC, '0);           // first fit picks the lower one
        issue(CMD_QUERY, 12'd2);
        issue(CMD_UNUSED, '0);

        // small total: edges of the range
        set_total(13'd100);
        issue(CMD_FREE, 12'd100);       // just out of range
        issue(CMD_FREE, 12'd99);
        issue(CMD_QUERY, 12'd100);
        issue(CMD_QUERY, 12'd99);
        issue(CMD_ALLOC, '0);
        issue(CMD_ALLOC, '0);
        issue(CMD_ALLOC, '0);           // no space left

        for (int p = 0; p < PHASES; p++)
        begin
            // one full phase with no idling on either side
            steady = (p == 5);
            run_phase(totals[p], counts[p]);
        end
        steady = 1'b0;

        // drain, then let any stray result show up
        req.valid <= 1'b0;
        do @(posedge clk); while (results_due != 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_total == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end
endmodule

>>> block_bitmap_allocator_unit.f
src/bba_pkg.sv
src/bba_cmd_if.sv
src/bba_rsp_if.sv
src/bba_cfg_if.sv
src/bba_map_ram.sv
src/bba_word_scan.sv
src/block_bitmap_allocator_unit.sv
verif/bba_alloc_checker.sv
verif/tb_top.sv
